/* src/cph_pkg.sv */
// shared types, constants and mixer helper functions for the coordinate pair hash
`default_nettype none

package cph_pkg;

    typedef logic [1:0] cph_mode_t;

    // mode register bits
    localparam int unsigned MODE_TWO_ROUND_BIT = 0;
    localparam int unsigned MODE_PLAIN_BIT     = 1;

    localparam cph_mode_t MODE_RESET = 2'd0;

    // lowbias32 multipliers
    localparam logic [31:0] LB_K1 = 32'h7feb_352d;
    localparam logic [31:0] LB_K2 = 32'h846c_a68b;
    // two-round mixer multipliers
    localparam logic [31:0] TR_K1 = 32'h21f0_aaad;
    localparam logic [31:0] TR_K2 = 32'hd35a_2d97;
    // pair combine constant
    localparam logic [31:0] GOLDEN = 32'h9e37_79b9;

    // word that travels down the multiplier stages
    typedef struct packed {
        cph_mode_t   mode;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] plain;
    } cph_word_t;

    function automatic logic is_two_round(input cph_mode_t mode);
        return mode[MODE_TWO_ROUND_BIT];
    endfunction

    function automatic logic is_plain(input cph_mode_t mode);
        return mode[MODE_PLAIN_BIT];
    endfunction

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

    function automatic logic [31:0] xs16(input logic [31:0] v);
        return v ^ (v >> 16);
    endfunction

    function automatic logic [31:0] xs15(input logic [31:0] v);
        return v ^ (v >> 15);
    endfunction

    // closing shift-xor of a mixer
    function automatic logic [31:0] mix_tail(input logic [31:0] v, input logic two_round);
        return two_round ? xs15(v) : xs16(v);
    endfunction

    function automatic logic [31:0] first_k(input logic two_round);
        return two_round ? TR_K1 : LB_K1;
    endfunction

    function automatic logic [31:0] second_k(input logic two_round);
        return two_round ? TR_K2 : LB_K2;
    endfunction

endpackage

`default_nettype wire

/* src/coordinate_pair_hash.sv */
// top level of the coordinate pair hash: four multiplier stages and an output register
`default_nettype none

// Hashes a pair of 32-bit grid coordinates (x, y) into a 32-bit value, one request
// per clock while the result side takes results. In mode 0 (lowbias32) and mode 1
// (two-round mixer) the result is mix(mix(x) ^ rot16(mix(y)) ^ 0x9e3779b9); in
// modes 2 and 3 it is x ^ rot16(y). An accepted request passes through stages 1
// to 4 and then the output register, and a stall on the result side holds it
// back. The first mix of x and y takes two multiplier stages, the mix of the
// combined word takes two more, and the closing shift-xor and mode select land in
// the output register. Every stage takes a new word each cycle unless it is held,
// so the sustained rate is one request per cycle while the result side is ready;
// back-pressure on the result side ripples up through the stage valid bits, and
// a stage only holds when it is full and the one below it is stuck, so bubbles
// are squeezed out. The mode is sampled with each request, and cfg_wr_en writes
// the mode register with the low two bits of cfg_wdata; write it only while no
// request is in flight.
module coordinate_pair_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // mode register write
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wdata,
    // coordinate requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] x_coord, [63:32] y_coord
    // hash results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] hash_value
);
    import cph_pkg::*;

    cph_mode_t mixer_mode_reg;

    // stage handshakes and words
    logic      s1_valid, s2_valid, s3_valid, s4_valid;
    logic      s2_ready, s3_ready, s4_ready, out_ready_int;
    cph_word_t s0_word, s1_word, s2_word, s3_word, s4_word;
    cph_word_t s1_fwd, s2_fwd, s3_fwd;
    logic [31:0] k0, k1, k2, k3;

    // output register
    logic        out_valid_reg;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    logic [31:0] x_in, y_in;
    logic [31:0] pair_fa, pair_fb, pair_h;

    // mode register, two bits only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mixer_mode_reg <= MODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            mixer_mode_reg <= cfg_wdata;
        end
    end

    assign x_in = s_axis_tdata[31:0];
    assign y_in = s_axis_tdata[63:32];

    // entry: opening shift-xor is the same for both mixers
    always_comb
    begin
        s0_word.mode  = mixer_mode_reg;
        s0_word.a     = xs16(x_in);
        s0_word.b     = xs16(y_in);
        // weak control result rides along untouched
        s0_word.plain = x_in ^ rot16(y_in);
        k0            = first_k(is_two_round(mixer_mode_reg));
    end

    // stage 1: first multiply of mix(x), mix(y)
    cph_mul_stage u_stage1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s0_word),
        .mul_k     (k0),
        .out_valid (s1_valid),
        .out_ready (s2_ready),
        .out_word  (s1_word)
    );

    always_comb
    begin
        s1_fwd   = s1_word;
        s1_fwd.a = xs15(s1_word.a);
        s1_fwd.b = xs15(s1_word.b);
        k1       = second_k(is_two_round(s1_word.mode));
    end

    // stage 2: second multiply of mix(x), mix(y)
    cph_mul_stage u_stage2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s2_ready),
        .in_word   (s1_fwd),
        .mul_k     (k1),
        .out_valid (s2_valid),
        .out_ready (s3_ready),
        .out_word  (s2_word)
    );

    // close both mixes, combine the pair, open the outer mix
    always_comb
    begin
        pair_fa  = mix_tail(s2_word.a, is_two_round(s2_word.mode));
        pair_fb  = mix_tail(s2_word.b, is_two_round(s2_word.mode));
        pair_h   = pair_fa ^ rot16(pair_fb) ^ GOLDEN;
        s2_fwd   = s2_word;
        s2_fwd.a = xs16(pair_h);
        // lane b is done, keep it quiet
        s2_fwd.b = '0;
        k2       = first_k(is_two_round(s2_word.mode));
    end

    // stage 3: first multiply of the outer mix
    cph_mul_stage u_stage3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s3_ready),
        .in_word   (s2_fwd),
        .mul_k     (k2),
        .out_valid (s3_valid),
        .out_ready (s4_ready),
        .out_word  (s3_word)
    );

    always_comb
    begin
        s3_fwd   = s3_word;
        s3_fwd.a = xs15(s3_word.a);
        k3       = second_k(is_two_round(s3_word.mode));
    end

    // stage 4: second multiply of the outer mix
    cph_mul_stage u_stage4 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s4_ready),
        .in_word   (s3_fwd),
        .mul_k     (k3),
        .out_valid (s4_valid),
        .out_ready (out_ready_int),
        .out_word  (s4_word)
    );

    // closing shift-xor and mode select
    always_comb
    begin
        if (is_plain(s4_word.mode))
        begin
            hash_next = s4_word.plain;
        end
        else
        begin
            hash_next = mix_tail(s4_word.a, is_two_round(s4_word.mode));
        end
    end

    assign out_ready_int = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready_int)
        begin
            out_valid_reg <= s4_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready_int && s4_valid)
        begin
            hash_reg <= hash_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = hash_reg;

    // a free result side lets every stage move, so the input never stalls
    a_no_stall_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready
    ) else $error("input stalled although the result side is ready");

    // a finished word in stage 4 reaches the output register when it has room
    a_stage4_to_out: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s4_valid && out_ready_int) |=> m_axis_tvalid
    ) else $error("stage 4 word lost on the way to the output");

    // weak control results carry the plain xor-rotate word
    a_plain_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s4_valid && out_ready_int && is_plain(s4_word.mode))
            |=> (m_axis_tdata == $past(s4_word.plain))
    ) else $error("plain mode result differs from the carried xor-rotate word");

    // mode is sampled with the request into stage 1
    a_mode_sampled: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready)
            |=> (s1_valid && s1_word.mode == $past(mixer_mode_reg))
    ) else $error("stage 1 did not capture the request mode");

endmodule

`default_nettype wire

/* src/cph_mul_stage.sv */
// one pipeline stage: multiplies both lanes by a constant and registers the word
`default_nettype none

module cph_mul_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cph_pkg::cph_word_t in_word,
    input  wire logic [31:0]        mul_k,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cph_pkg::cph_word_t      out_word
);
    import cph_pkg::*;

    logic      valid_reg;
    cph_word_t word_reg;
    cph_word_t word_next;

    // stage moves when empty or when downstream takes its request
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        word_next       = in_word;
        word_next.a     = in_word.a * mul_k;
        word_next.b     = in_word.b * mul_k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire
